### rtl/core/lrat_pkg.sv
package lrat_pkg;

  // Table geometry.
  localparam int ACTIVE_SLOTS = 8;
  localparam int ID_BITS      = 8;

  // Range kinds carried in the mode field.
  localparam logic [1:0] MODE_NUM_NUM = 2'd0;
  localparam logic [1:0] MODE_NUM_PAT = 2'd1;
  localparam logic [1:0] MODE_PAT_NUM = 2'd2;
  localparam logic [1:0] MODE_PAT_PAT = 2'd3;

  typedef logic [ACTIVE_SLOTS-1:0] slot_vec_t;
  typedef logic [ID_BITS-1:0]      id_t;

  // One query word.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  range_id;
    logic [31:0] line_number;
    logic [31:0] start_line;
    logic [31:0] end_line;
    logic        start_match;
    logic        end_match;
  } query_t;

  // One result word.
  typedef struct packed {
    logic selected;
    logic table_full;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Keeps only the lowest set bit, so the first slot wins.
  function automatic slot_vec_t first_one(input slot_vec_t v);
    return v & (~v + slot_vec_t'(1));
  endfunction

endpackage

### rtl/core/line_range_address_tracker_top.sv
// Line range address tracker.
// Query channel: query_valid, query_stall, query (a query_t word). A word
// carries the range kind, range id, line number, numeric bounds and the
// pattern match bits. The block raises query_stall while it works on a word.
// Result channel: result_valid, result_stall, result (a result_t word) with
// the selected bit and a table_full flag raised when a range had to be
// stored but its table had no free slot.
// Steps: a word taken in the accept step is registered, the compare step
// registers the slot matches and line compares, and the write step updates
// the tables and loads the output register. A new word is not taken until
// the write step of the last one is done, as the accept, compare and write
// steps share the single pair of slot tables.
// A new word is taken while an earlier result still waits; if the receiver
// stalls, the write step holds until the output register is free, and
// result holds steady while result_stall is high.
// Reset (rst, synchronous) empties both slot tables at once, drops
// result_valid and returns the controller to idle.
module line_range_address_tracker_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_stall,
  input  lrat_pkg::query_t   query,
  output logic               result_valid,
  input  logic               result_stall,
  output lrat_pkg::result_t  result
);

  lrat_pkg::ctrl_cmd_t  cmd;
  lrat_pkg::dp_status_t status;

  // Sequencer.
  lrat_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Slot tables, compares and output register.
  lrat_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .query        (query),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### rtl/core/lrat_ctrl.sv
module lrat_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    query_valid,
  output logic                    query_stall,
  input  lrat_pkg::dp_status_t    status,
  output lrat_pkg::ctrl_cmd_t     cmd
);

  lrat_pkg::state_t state;
  lrat_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    query_stall = 1'b1;
    case (state)
      lrat_pkg::ST_IDLE: begin
        query_stall = 1'b0;
        if (query_valid) begin
          cmd.load   = 1'b1;
          state_next = lrat_pkg::ST_CMP;
        end
      end
      lrat_pkg::ST_CMP: begin
        cmd.capture = 1'b1;
        state_next  = lrat_pkg::ST_WRITE;
      end
      lrat_pkg::ST_WRITE: begin
        // Wait until the output register can take the result.
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = lrat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrat_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_then_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.capture)
    else $error("compare step did not follow an accepted word");
  a_commit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (!query_stall && !cmd.capture))
    else $error("controller did not return to idle after commit");
  a_no_commit_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state == lrat_pkg::ST_WRITE && status.out_busy) |=> !$past(cmd.commit))
    else $error("result committed while output register was stalled");
`endif

endmodule

### rtl/core/lrat_dp.sv
module lrat_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lrat_pkg::query_t      query,
  input  lrat_pkg::ctrl_cmd_t   cmd,
  output lrat_pkg::dp_status_t  status,
  input  logic                  result_stall,
  output logic                  result_valid,
  output lrat_pkg::result_t     result
);

  // Slot tables; zero marks an empty slot.
  lrat_pkg::id_t active_ids [lrat_pkg::ACTIVE_SLOTS];
  lrat_pkg::id_t ended_ids  [lrat_pkg::ACTIVE_SLOTS];

  lrat_pkg::query_t q;
  lrat_pkg::id_t    id;
  logic             id_nz;

  // Registered compare results.
  lrat_pkg::slot_vec_t act_eq_q, end_eq_q, act_free_q, end_free_q;
  logic ge_start_q, le_end_q, eq_start_q, lt_end_q;

  // Decision for the write step.
  lrat_pkg::slot_vec_t set_act, clr_act, set_end;
  lrat_pkg::slot_vec_t hit_oh, act_oh, free_act_oh, free_end_oh;
  logic sel, full, any_hit, ended_hit, act_found, begin_range;

  assign id    = lrat_pkg::ID_BITS'(q.range_id);
  assign id_nz = (id != '0);

  // Query register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= query;
    end
  end

  // Compare step: slot matches, free slots and line compares.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < lrat_pkg::ACTIVE_SLOTS; i++) begin
        act_eq_q[i]   <= id_nz && (active_ids[i] == id);
        end_eq_q[i]   <= id_nz && (ended_ids[i] == id);
        act_free_q[i] <= (active_ids[i] == '0);
        end_free_q[i] <= (ended_ids[i] == '0);
      end
      ge_start_q <= (q.line_number >= q.start_line);
      le_end_q   <= (q.line_number <= q.end_line);
      eq_start_q <= (q.line_number == q.start_line);
      lt_end_q   <= (q.line_number < q.end_line);
    end
  end

  assign hit_oh      = lrat_pkg::first_one(act_eq_q | end_eq_q);
  assign any_hit     = |(act_eq_q | end_eq_q);
  assign ended_hit   = |(hit_oh & end_eq_q);
  assign act_oh      = lrat_pkg::first_one(act_eq_q);
  assign act_found   = |act_eq_q;
  assign free_act_oh = lrat_pkg::first_one(act_free_q);
  assign free_end_oh = lrat_pkg::first_one(end_free_q);

  // Write step: selection, slot frees and slot fills.
  always_comb begin
    sel         = 1'b0;
    full        = 1'b0;
    set_act     = '0;
    clr_act     = '0;
    set_end     = '0;
    begin_range = 1'b0;
    if (q.mode == lrat_pkg::MODE_NUM_PAT) begin
      if (ended_hit) begin
        sel = 1'b0;
      end else if (any_hit) begin
        sel = 1'b1;
        if (q.end_match) begin
          clr_act = hit_oh;
          set_end = free_end_oh;
          full    = (free_end_oh == '0);
        end
      end else if (ge_start_q) begin
        sel = 1'b1;
        if (id_nz) begin
          if (q.end_match) begin
            set_end = free_end_oh;
            full    = (free_end_oh == '0);
          end else begin
            set_act = free_act_oh;
            full    = (free_act_oh == '0);
          end
        end
      end
    end else if (act_found) begin
      if (q.mode == lrat_pkg::MODE_PAT_PAT) begin
        sel = 1'b1;
        if (q.end_match) begin
          clr_act = act_oh;
        end
      end else begin
        sel = le_end_q;
        if (!lt_end_q) begin
          clr_act = act_oh;
        end
      end
    end else begin
      if (q.mode == lrat_pkg::MODE_NUM_NUM) begin
        begin_range = eq_start_q || (ge_start_q && le_end_q);
      end else begin
        begin_range = q.start_match;
      end
      if (begin_range) begin
        sel = 1'b1;
        if (id_nz && (q.mode == lrat_pkg::MODE_PAT_PAT || lt_end_q)) begin
          set_act = free_act_oh;
          full    = (free_act_oh == '0);
        end
      end
    end
  end

  // Table update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lrat_pkg::ACTIVE_SLOTS; i++) begin
        active_ids[i] <= '0;
        ended_ids[i]  <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < lrat_pkg::ACTIVE_SLOTS; i++) begin
        if (set_act[i]) begin
          active_ids[i] <= id;
        end else if (clr_act[i]) begin
          active_ids[i] <= '0;
        end
        if (set_end[i]) begin
          ended_ids[i] <= id;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.selected   <= sel;
      result.table_full <= full;
    end
  end

  assign status.out_busy = result_valid && result_stall;

`ifndef SYNTHESIS
  a_active_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $onehot0(act_eq_q))
    else $error("range id held in more than one active slot");
  a_fill_clear_apart: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ((set_act & clr_act) == '0))
    else $error("active slot filled and freed in the same step");
  a_full_no_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && full) |-> (set_act == '0 && set_end == '0))
    else $error("table full flagged while a slot was filled");
`endif

endmodule
